/* hdl/fpx_pkg.sv */
// Package for the frame packer with XOR check.
// Holds the request types, the function codes and the result job type.
// No dependencies.
package fpx_pkg;

  // Number of header bytes and the largest number of results for one request.
  localparam int unsigned HdrBytes = 21;
  localparam int unsigned MaxRes   = HdrBytes + 1;
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);

  // Function codes of an input request.
  localparam logic FuncHeader = 1'b0;
  localparam logic FuncBody   = 1'b1;

  // One input request.
  typedef struct packed {
    logic        func;
    logic [15:0] msg_id;
    logic [31:0] sequence_number;
    logic [31:0] package_count;
    logic [31:0] package_number;
    logic [31:0] timestamp;
    logic [7:0]  flag_byte;
    logic [15:0] body_length;
    logic [7:0]  body_byte;
  } in_t;

  // One output request.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
    logic       error;
  } out_t;

  // All results caused by one input request; byte 0 sits in the low bits.
  typedef struct packed {
    logic [MaxRes*8-1:0] bytes;
    logic [ResCntW-1:0]  cnt;
    logic                chk_end;
    logic                err;
  } job_t;

endpackage

/* hdl/fpx_frame_ctl.sv */
// Frame state and result formation for the frame packer.
// Turns each accepted request into a job of result bytes and updates the
// running check, the remaining body count and the open flag. Uses fpx_pkg.
module fpx_frame_ctl import fpx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_req_i,
  input  logic accept_i,
  output job_t job_o
);

  logic [7:0]  chk_q, chk_d;
  logic [15:0] left_q, left_d;
  logic        open_q, open_d;

  logic [HdrBytes*8-1:0] hdr;
  logic [7:0]            hdr_chk;
  logic [7:0]            body_chk;
  logic [15:0]           body_left;

  // Header bytes in wire order, first byte in the top bits.
  assign hdr = {in_req_i.msg_id, in_req_i.sequence_number, in_req_i.package_count,
                in_req_i.package_number, in_req_i.timestamp, in_req_i.flag_byte,
                in_req_i.body_length};

  assign body_chk  = chk_q ^ in_req_i.body_byte;
  assign body_left = left_q - 16'd1;

  // Build the job and the next frame state.
  always_comb begin
    job_o   = '0;
    hdr_chk = '0;
    chk_d   = chk_q;
    left_d  = left_q;
    open_d  = open_q;
    if (in_req_i.func == FuncHeader) begin
      for (int i = 0; i < HdrBytes; i++) begin
        job_o.bytes[i*8 +: 8] = hdr[(HdrBytes-1-i)*8 +: 8];
        hdr_chk               = hdr_chk ^ hdr[i*8 +: 8];
      end
      if (in_req_i.body_length == 16'd0) begin
        // Empty body: the check byte closes the frame at once.
        job_o.bytes[HdrBytes*8 +: 8] = hdr_chk;
        job_o.cnt     = ResCntW'(MaxRes);
        job_o.chk_end = 1'b1;
        chk_d         = '0;
        left_d        = '0;
        open_d        = 1'b0;
      end else begin
        job_o.cnt = ResCntW'(HdrBytes);
        chk_d     = hdr_chk;
        left_d    = in_req_i.body_length;
        open_d    = 1'b1;
      end
    end else if (!open_q) begin
      // Body byte outside a frame reports an error and leaves the state alone.
      job_o.cnt = ResCntW'(1);
      job_o.err = 1'b1;
    end else begin
      job_o.bytes[7:0] = in_req_i.body_byte;
      chk_d            = body_chk;
      left_d           = body_left;
      if (body_left == 16'd0) begin
        // Last body byte: echo it, then send the check byte.
        job_o.bytes[15:8] = body_chk;
        job_o.cnt         = ResCntW'(2);
        job_o.chk_end     = 1'b1;
        chk_d             = '0;
        open_d            = 1'b0;
      end else begin
        job_o.cnt = ResCntW'(1);
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q  <= '0;
      left_q <= '0;
      open_q <= 1'b0;
    end else if (accept_i) begin
      chk_q  <= chk_d;
      left_q <= left_d;
      open_q <= open_d;
    end
  end

endmodule

/* hdl/fpx_serializer.sv */
// Job register and output register for the frame packer.
// Shifts the bytes of one job out one per cycle, unless the output stalls,
// through a registered output stage with valid and ready. Uses fpx_pkg.
module fpx_serializer import fpx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t job_i,
  input  logic load_i,
  output logic ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_req_o
);

  logic                job_valid_q;
  logic [MaxRes*8-1:0] bytes_q;
  logic [ResCntW-1:0]  rem_q;
  logic                chk_end_q;
  logic                err_q;
  logic                out_valid_q;
  out_t                out_q;
  logic                adv;
  logic                rem_last;

  // A byte moves to the output stage when that stage is empty or drains.
  assign adv      = job_valid_q && (!out_valid_q || out_ready_i);
  assign rem_last = (rem_q == ResCntW'(1));
  assign ready_o  = !job_valid_q || (adv && rem_last);

  // Job register: loads a new job or shifts out the next byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (load_i) begin
      job_valid_q <= 1'b1;
    end else if (adv && rem_last) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q   <= job_i.bytes;
      rem_q     <= job_i.cnt;
      chk_end_q <= job_i.chk_end;
      err_q     <= job_i.err;
    end else if (adv) begin
      bytes_q <= bytes_q >> 8;
      rem_q   <= rem_q - ResCntW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_byte    <= bytes_q[7:0];
      out_q.last_of_run <= rem_last;
      out_q.frame_end   <= chk_end_q && rem_last;
      out_q.error       <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* hdl/frame_packer_xor_check.sv */
// Frame packer with XOR check byte: serializes header and body requests.
// The first result of a request passes the job register, then the output register.
// One result per cycle leaves the output register unless out_ready_i stalls; a new
// request is taken only once the last result of the previous job moves out.
// Reset (rst_ni, asynchronous, active low) closes any frame and clears the check.
module frame_packer_xor_check import fpx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_req_o
);

  job_t job;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  // Frame state and job formation.
  fpx_frame_ctl u_ctl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_req_i),
    .accept_i (accept),
    .job_o    (job)
  );

  // Byte serialization and output stage.
  fpx_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .load_i      (accept),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  // An error result is always a run of its own.
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_req_o.error || out_req_o.last_of_run))
    else $error("error result without last_of_run");

  // The check byte ends its run and is never an error.
  a_chk_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.frame_end) |-> (out_req_o.last_of_run && !out_req_o.error))
    else $error("check byte not last of run or flagged as error");

  // A run continues without a gap once one of its results is taken.
  a_run_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_req_o.last_of_run) |=> out_valid_o)
    else $error("gap inside a result run");

endmodule

/* bench/tb.sv */
// Testbench for frame_packer_xor_check: directed table, then random frames.
// Checks every serialized byte against an in-bench frame predictor.
// Depends on fpx_pkg and the frame_packer_xor_check RTL.
`timescale 1ns / 1ps

module tb;
  import fpx_pkg::*;

  // One row of the directed table; res is the typed-in final result of the row.
  typedef struct {
    in_t  req;
    bit   typed;
    out_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_req_o;

  // Predictor state: running check, body bytes still due, frame open.
  logic [7:0]  chk_acc;
  logic [15:0] body_left;
  logic        frame_open;

  out_t      frame_bytes_q[$];
  stim_row_t dir_rows[$];
  int        item_idx;
  int        res_cnt;
  int        err_cnt;
  bit        hold_rx;

  frame_packer_xor_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  // Clock with a 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Work out the bytes that one request puts on the output, and update the frame state.
  function automatic void pack_predict(input in_t req, ref out_t res[$]);
    logic [167:0] hdr;
    logic [7:0]   b;
    logic [7:0]   chk;
    int           i;
    res.delete();
    if (req.func == FuncHeader) begin
      hdr = {req.msg_id, req.sequence_number, req.package_count, req.package_number,
             req.timestamp, req.flag_byte, req.body_length};
      chk = '0;
      for (i = 0; i < HdrBytes; i++) begin
        b   = hdr[167 - 8*i -: 8];
        chk = chk ^ b;
        res.push_back(out_t'{out_byte: b,
                             last_of_run: (req.body_length != 0 && i == HdrBytes - 1),
                             frame_end: 1'b0, error: 1'b0});
      end
      if (req.body_length == 0) begin
        // Empty body: the check byte follows the header at once.
        res.push_back(out_t'{out_byte: chk, last_of_run: 1'b1, frame_end: 1'b1, error: 1'b0});
        chk_acc    = '0;
        body_left  = '0;
        frame_open = 1'b0;
      end else begin
        chk_acc    = chk;
        body_left  = req.body_length;
        frame_open = 1'b1;
      end
    end else if (!frame_open) begin
      // Stray body byte: a lone error result, state untouched.
      res.push_back(out_t'{out_byte: 8'h00, last_of_run: 1'b1, frame_end: 1'b0, error: 1'b1});
    end else begin
      b         = req.body_byte;
      chk_acc   = chk_acc ^ b;
      body_left = body_left - 16'd1;
      if (body_left == 0) begin
        res.push_back(out_t'{out_byte: b, last_of_run: 1'b0, frame_end: 1'b0, error: 1'b0});
        res.push_back(out_t'{out_byte: chk_acc, last_of_run: 1'b1, frame_end: 1'b1,
                             error: 1'b0});
        chk_acc    = '0;
        frame_open = 1'b0;
      end else begin
        res.push_back(out_t'{out_byte: b, last_of_run: 1'b1, frame_end: 1'b0, error: 1'b0});
      end
    end
  endfunction

  // A request with every field random.
  function automatic in_t rand_req();
    in_t r;
    r.func            = 1'($urandom_range(1));
    r.msg_id          = 16'($urandom);
    r.sequence_number = $urandom;
    r.package_count   = $urandom;
    r.package_number  = $urandom;
    r.timestamp       = $urandom;
    r.flag_byte       = 8'($urandom);
    r.body_length     = 16'($urandom);
    r.body_byte       = 8'($urandom);
    return r;
  endfunction

  function automatic in_t hdr_req(input logic [15:0] id, input logic [31:0] sq,
                                  input logic [31:0] cnt, input logic [31:0] num,
                                  input logic [31:0] ts, input logic [7:0] flg,
                                  input logic [15:0] len);
    in_t r;
    r                 = rand_req();
    r.func            = FuncHeader;
    r.msg_id          = id;
    r.sequence_number = sq;
    r.package_count   = cnt;
    r.package_number  = num;
    r.timestamp       = ts;
    r.flag_byte       = flg;
    r.body_length     = len;
    return r;
  endfunction

  function automatic in_t body_req(input logic [7:0] b);
    in_t r;
    r           = rand_req();
    r.func      = FuncBody;
    r.body_byte = b;
    return r;
  endfunction

  function automatic void add_row(input in_t req, input bit typed, input out_t res);
    stim_row_t row;
    row.req   = req;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  // Offer one request, wait for it to be taken, and queue the bytes it should produce.
  task automatic offer_req(input in_t req, input bit typed, input out_t typed_res);
    out_t res[$];
    bit   tx_calm;
    @(negedge clk_i);
    tx_calm = (item_idx >= 60 && item_idx < 110);
    while (!tx_calm && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pack_predict(req, res);
    if (typed) res[res.size() - 1] = typed_res;
    foreach (res[k]) frame_bytes_q.push_back(res[k]);
    item_idx++;
    // Once, the receiver holds off for a long stretch while requests keep coming.
    if (item_idx == 120) hold_rx = 1'b1;
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  initial begin : rx_side
    int hold_cycles;
    hold_cycles = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        hold_rx     = 1'b0;
        hold_cycles = 200;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (!(res_cnt >= 150 && res_cnt < 450) && $urandom_range(99) < 10) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each result taken from the block with the oldest expected byte.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_cnt++;
      if (frame_bytes_q.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected result: byte %02h last %0b end %0b err %0b",
                   out_req_o.out_byte, out_req_o.last_of_run, out_req_o.frame_end,
                   out_req_o.error);
        err_cnt++;
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_req_o.out_byte !== want.out_byte || out_req_o.last_of_run !== want.last_of_run
            || out_req_o.frame_end !== want.frame_end || out_req_o.error !== want.error) begin
          if (err_cnt < 10)
            $display({"mismatch at result %0d: expected byte %02h last %0b end %0b err %0b,",
                      " got byte %02h last %0b end %0b err %0b"},
                     res_cnt, want.out_byte, want.last_of_run, want.frame_end, want.error,
                     out_req_o.out_byte, out_req_o.last_of_run, out_req_o.frame_end,
                     out_req_o.error);
          err_cnt++;
        end
      end
    end
  end

  // Hard limit on the run time.
  initial begin
    #1_600_000;
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence: reset, directed table, random frames, drain.
  initial begin
    in_t  req;
    out_t none;
    int   pick;
    int   n;
    chk_acc    = '0;
    body_left  = '0;
    frame_open = 1'b0;
    item_idx   = 0;
    res_cnt    = 0;
    err_cnt    = 0;
    hold_rx    = 1'b0;
    none       = '0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: error cases, extremes, abandoned frames, an ordinary frame.
    add_row(body_req(8'h5A), 1'b1, out_t'{8'h00, 1'b1, 1'b0, 1'b1});
    add_row(hdr_req('0, '0, '0, '0, '0, '0, 16'h0000), 1'b1, out_t'{8'h00, 1'b1, 1'b1, 1'b0});
    add_row(hdr_req('1, '1, '1, '1, '1, '1, 16'h0000), 1'b1, out_t'{8'hFF, 1'b1, 1'b1, 1'b0});
    add_row(hdr_req('0, '0, '0, '0, '0, '0, 16'h0001), 1'b1, out_t'{8'h01, 1'b1, 1'b0, 1'b0});
    add_row(body_req(8'hFF), 1'b1, out_t'{8'hFE, 1'b1, 1'b1, 1'b0});
    add_row(body_req(8'h00), 1'b1, out_t'{8'h00, 1'b1, 1'b0, 1'b1});
    add_row(hdr_req('1, '1, '1, '1, '1, '1, 16'hFFFF), 1'b1, out_t'{8'hFF, 1'b1, 1'b0, 1'b0});
    add_row(body_req(8'h00), 1'b0, none);
    add_row(body_req(8'hFF), 1'b0, none);
    // A new header while a frame is open drops the old frame.
    add_row(hdr_req(16'($urandom), $urandom, $urandom, $urandom, $urandom, 8'($urandom),
                    16'd3), 1'b0, none);
    add_row(body_req(8'($urandom)), 1'b0, none);
    add_row(hdr_req(16'($urandom), $urandom, $urandom, $urandom, $urandom, 8'($urandom),
                    16'd2), 1'b0, none);
    add_row(body_req(8'($urandom)), 1'b0, none);
    add_row(body_req(8'($urandom)), 1'b0, none);
    add_row(body_req(8'h33), 1'b1, out_t'{8'h00, 1'b1, 1'b0, 1'b1});
    add_row(hdr_req(16'h1234, 32'h0102_0304, 32'h0000_0010, 32'h0000_0003, 32'h89AB_CDEF,
                    8'h80, 16'd4), 1'b0, none);
    add_row(body_req(8'h01), 1'b0, none);
    add_row(body_req(8'h80), 1'b0, none);
    add_row(body_req(8'h7F), 1'b0, none);
    add_row(body_req(8'hC3), 1'b0, none);
    add_row(hdr_req(16'($urandom), $urandom, $urandom, $urandom, $urandom, 8'($urandom),
                    16'd0), 1'b0, none);

    foreach (dir_rows[r]) offer_req(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].res);

    // Random part: mostly complete frames, some abandoned frames and stray body bytes.
    while (item_idx < dir_rows.size() + 160) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        req      = rand_req();
        req.func = FuncBody;
        offer_req(req, 1'b0, none);
      end else begin
        req      = rand_req();
        req.func = FuncHeader;
        if (pick < 14) begin
          // Full-range length, cut short by whatever comes next.
          n = $urandom_range(3);
        end else begin
          req.body_length = 16'((pick < 30) ? $urandom_range(24, 7) : $urandom_range(6, 0));
          n               = int'(req.body_length);
        end
        offer_req(req, 1'b0, none);
        repeat (n) begin
          req      = rand_req();
          req.func = FuncBody;
          offer_req(req, 1'b0, none);
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then keep watching for anything stray before the verdict.
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (err_cnt == 0 && frame_bytes_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/fpx_pkg.sv
hdl/fpx_frame_ctl.sv
hdl/fpx_serializer.sv
hdl/frame_packer_xor_check.sv
bench/tb.sv
